// File: hw/rtl/gila_pkg.sv
// ----------------------------------------------------------------------------
// gila_pkg
// shared constants, codes and types of the greedy interval lane assigner
// ----------------------------------------------------------------------------
package gila_pkg;

  localparam int MAX_ACTIONS = 256;
  localparam int ADDR_W      = $clog2(MAX_ACTIONS);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int LANE_W      = ADDR_W;
  localparam int SLANE_W     = 9;
  localparam int FRAME_W     = 20;
  localparam int TARGET_W    = 10;
  localparam int KIND_W      = 2;
  localparam int CFG_W       = 8;
  localparam int PITCH_W     = CFG_W + 1;
  localparam int BOX_W       = 18;
  localparam int PROD_W      = BOX_W + 1;
  localparam int WANT_W      = TARGET_W + 1;

  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_SEL_W = $clog2(CHUNK_BITS);
  localparam int NUM_CHUNKS  = MAX_ACTIONS / CHUNK_BITS;
  localparam int CHUNK_W     = $clog2(NUM_CHUNKS);

  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [KIND_W-1:0] KIND_UNIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOOST = 2'd1;

  localparam logic [1:0] REG_INITIAL_UNITS = 2'd0;
  localparam logic [1:0] REG_BOX_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_BOX_GAP       = 2'd2;

  localparam logic [CFG_W-1:0] INITIAL_UNITS_RST = 8'd0;
  localparam logic [CFG_W-1:0] BOX_HEIGHT_RST    = 8'd20;
  localparam logic [CFG_W-1:0] BOX_GAP_RST       = 8'd3;

  localparam logic [SLANE_W-1:0] NO_LANE = '1;

  typedef struct packed {
    logic [CFG_W-1:0] initial_units;
    logic [CFG_W-1:0] box_height;
    logic [CFG_W-1:0] box_gap;
  } cfg_t;

  typedef struct packed {
    logic               is_ability;
    logic [FRAME_W-1:0] finish;
    logic [SLANE_W-1:0] lane;
    logic [SLANE_W-1:0] index;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              clear;
    logic              mark;
    logic [LANE_W-1:0] mark_lane;
    logic              start;
  } lane_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [LANE_W-1:0] lane;
  } lane_stat_t;

endpackage

// File: hw/rtl/gila_act_if.sv
// ----------------------------------------------------------------------------
// gila_act_if
// request channel: one action per accepted request
// ----------------------------------------------------------------------------
interface gila_act_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [gila_pkg::KIND_W-1:0]   kind;
  logic [gila_pkg::FRAME_W-1:0]  start_frame;
  logic [gila_pkg::FRAME_W-1:0]  finish_frame;
  logic [gila_pkg::TARGET_W-1:0] target_id;

  modport source(
    output valid, restart, kind, start_frame, finish_frame, target_id,
    input  ready
  );
  modport sink(
    input  valid, restart, kind, start_frame, finish_frame, target_id,
    output ready
  );
endinterface

// File: hw/rtl/gila_res_if.sv
// ----------------------------------------------------------------------------
// gila_res_if
// result channel: lane, production index, box extent and largest lane per action
// ----------------------------------------------------------------------------
interface gila_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [gila_pkg::SLANE_W-1:0] lane;
  logic signed [gila_pkg::SLANE_W-1:0] production_index;
  logic signed [gila_pkg::BOX_W-1:0]   box_top;
  logic signed [gila_pkg::BOX_W-1:0]   box_bottom;
  logic [gila_pkg::LANE_W-1:0]         max_lane;

  modport source(
    output valid, lane, production_index, box_top, box_bottom, max_lane,
    input  ready
  );
  modport sink(
    input  valid, lane, production_index, box_top, box_bottom, max_lane,
    output ready
  );
endinterface

// File: hw/rtl/gila_ram.sv
// ----------------------------------------------------------------------------
// gila_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gila_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gila_cfg_regs.sv
// ----------------------------------------------------------------------------
// gila_cfg_regs
// apb register file: initial unit count, box height and box gap
// ----------------------------------------------------------------------------
module gila_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gila_pkg::PADDR_W-1:0]   paddr,
  input  logic [gila_pkg::PDATA_W-1:0]   pwdata,
  output logic [gila_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output gila_pkg::cfg_t                 cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_units <= gila_pkg::INITIAL_UNITS_RST;
      cfg.box_height    <= gila_pkg::BOX_HEIGHT_RST;
      cfg.box_gap       <= gila_pkg::BOX_GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        gila_pkg::REG_INITIAL_UNITS: cfg.initial_units <= pwdata[gila_pkg::CFG_W-1:0];
        gila_pkg::REG_BOX_HEIGHT:    cfg.box_height    <= pwdata[gila_pkg::CFG_W-1:0];
        gila_pkg::REG_BOX_GAP:       cfg.box_gap       <= pwdata[gila_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      gila_pkg::REG_INITIAL_UNITS: prdata[gila_pkg::CFG_W-1:0] = cfg.initial_units;
      gila_pkg::REG_BOX_HEIGHT:    prdata[gila_pkg::CFG_W-1:0] = cfg.box_height;
      gila_pkg::REG_BOX_GAP:       prdata[gila_pkg::CFG_W-1:0] = cfg.box_gap;
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/gila_free_lane.sv
// ----------------------------------------------------------------------------
// gila_free_lane
// busy-lane bitmap and chunked search for the lowest free lane
// ----------------------------------------------------------------------------
module gila_free_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  gila_pkg::lane_ctrl_t ctrl,
  output gila_pkg::lane_stat_t stat
);

  logic [gila_pkg::MAX_ACTIONS-1:0] busy;
  logic                             searching;
  logic [gila_pkg::CHUNK_W-1:0]     chunk;
  logic [gila_pkg::CHUNK_BITS-1:0]  chunk_bits;
  logic                             chunk_free;
  logic [gila_pkg::CHUNK_SEL_W-1:0] zero_pos;
  logic                             chunk_last;

  assign chunk_bits = busy[chunk*gila_pkg::CHUNK_BITS +: gila_pkg::CHUNK_BITS];
  assign chunk_free = ~&chunk_bits;
  assign chunk_last = (chunk == gila_pkg::CHUNK_W'(gila_pkg::NUM_CHUNKS - 1));

  // lowest clear bit of the current chunk
  always_comb begin
    zero_pos = '0;
    for (int b = gila_pkg::CHUNK_BITS - 1; b >= 0; b--) begin
      if (!chunk_bits[b]) begin
        zero_pos = gila_pkg::CHUNK_SEL_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      searching <= 1'b0;
      chunk     <= '0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (ctrl.clear) begin
        busy <= '0;
      end else if (ctrl.mark) begin
        busy[ctrl.mark_lane] <= 1'b1;
      end
      if (ctrl.start) begin
        searching <= 1'b1;
        chunk     <= '0;
      end else if (searching) begin
        if (chunk_free || chunk_last) begin
          searching <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          chunk <= chunk + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (searching && (chunk_free || chunk_last)) begin
      stat.lane <= {chunk, zero_pos};
    end
  end

endmodule

// File: hw/rtl/greedy_interval_lane_assigner_core.sv
// sequence: other abilities skip the scan; boosts scan the n actions stored so far
// and unit actions scan them and then search for the lowest free lane
// throughput: one action at a time, set by the scan of the entry ram, one
// stored entry per cycle, plus the lowest-free-lane search over 8-lane chunks
// reset: counters and largest lane clear, config registers take their defaults;
// the entry ram keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
// greedy_interval_lane_assigner_core
// assigns each unit action a lane by greedy interval partitioning, gives boosts
// their target's lane, and reports each production index and plotted box extent
// ----------------------------------------------------------------------------
module greedy_interval_lane_assigner_core (
  input  logic                         clk,
  input  logic                         rst,
  gila_act_if.sink                     act,
  gila_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gila_pkg::PADDR_W-1:0] paddr,
  input  logic [gila_pkg::PDATA_W-1:0] pwdata,
  output logic [gila_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_STORE  = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t                             state;
  gila_pkg::cfg_t                     cfg;
  gila_pkg::lane_ctrl_t               lane_ctrl;
  gila_pkg::lane_stat_t               lane_stat;
  gila_pkg::entry_t                   rd_entry;
  gila_pkg::entry_t                   wr_entry;
  logic [gila_pkg::ENTRY_W-1:0]       rd_data;

  logic [gila_pkg::KIND_W-1:0]        cur_kind;
  logic [gila_pkg::FRAME_W-1:0]       cur_start;
  logic [gila_pkg::FRAME_W-1:0]       cur_finish;
  logic signed [gila_pkg::WANT_W-1:0] cur_want;
  logic [gila_pkg::SLANE_W-1:0]       lane_r;
  logic [gila_pkg::SLANE_W-1:0]       pidx_r;
  logic [gila_pkg::BOX_W-1:0]         top_r;
  logic [gila_pkg::COUNT_W-1:0]       scan_addr;
  logic                               rd_pend;
  logic [gila_pkg::COUNT_W-1:0]       item_count;
  logic [gila_pkg::COUNT_W-1:0]       boost_count;
  logic [gila_pkg::LANE_W-1:0]        largest_lane;

  logic [gila_pkg::COUNT_W-1:0]       pos_eff;
  logic                               accept;
  logic                               scan_issue;
  logic                               scan_end;
  logic                               busy_hit;
  logic                               boost_hit;
  logic                               out_load;
  logic [gila_pkg::PITCH_W-1:0]       pitch;
  logic signed [gila_pkg::PROD_W-1:0] lane_w;
  logic signed [gila_pkg::PROD_W-1:0] pitch_w;
  logic signed [gila_pkg::PROD_W-1:0] prod;

  gila_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gila_ram #(
    .WIDTH (gila_pkg::ENTRY_W),
    .DEPTH (gila_pkg::MAX_ACTIONS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (state == ST_STORE),
    .waddr (item_count[gila_pkg::ADDR_W-1:0]),
    .wdata (wr_entry),
    .raddr (scan_addr[gila_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

  gila_free_lane u_free_lane (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lane_ctrl),
    .stat (lane_stat)
  );

  assign act.ready  = (state == ST_IDLE);
  assign accept     = act.valid && act.ready;
  assign pos_eff    = act.restart ? '0 : item_count;
  assign rd_entry   = rd_data;
  assign scan_issue = (state == ST_SCAN) && (scan_addr < item_count);
  assign scan_end   = (state == ST_SCAN) && !scan_issue && !rd_pend;
  assign out_load   = (state == ST_OUT) && (!res.valid || res.ready);

  assign wr_entry.is_ability = (cur_kind != gila_pkg::KIND_UNIT);
  assign wr_entry.finish     = cur_finish;
  assign wr_entry.lane       = lane_r;
  assign wr_entry.index      = pidx_r;

  // earlier unit action still running at this start
  assign busy_hit  = rd_pend && !rd_entry.is_ability && (cur_start < rd_entry.finish)
                     && !rd_entry.lane[gila_pkg::SLANE_W-1];
  assign boost_hit = rd_pend && (cur_want == gila_pkg::WANT_W'(signed'(rd_entry.index)));

  always_comb begin
    lane_ctrl.clear     = accept && (act.kind == gila_pkg::KIND_UNIT);
    lane_ctrl.mark      = busy_hit && (cur_kind == gila_pkg::KIND_UNIT);
    lane_ctrl.mark_lane = rd_entry.lane[gila_pkg::LANE_W-1:0];
    lane_ctrl.start     = scan_end && (cur_kind == gila_pkg::KIND_UNIT);
  end

  assign pitch   = gila_pkg::PITCH_W'(cfg.box_height) + gila_pkg::PITCH_W'(cfg.box_gap);
  assign lane_w  = gila_pkg::PROD_W'(signed'(lane_r));
  assign pitch_w = signed'(gila_pkg::PROD_W'(pitch));
  assign prod    = lane_w * pitch_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_addr    <= '0;
      rd_pend      <= 1'b0;
      item_count   <= '0;
      boost_count  <= '0;
      largest_lane <= '0;
      res.valid    <= 1'b0;
    end else begin
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (act.restart) begin
              item_count   <= '0;
              boost_count  <= '0;
              largest_lane <= '0;
            end
            scan_addr <= '0;
            rd_pend   <= 1'b0;
            if (pos_eff == gila_pkg::COUNT_W'(gila_pkg::MAX_ACTIONS)) begin
              state <= ST_MUL;
            end else if (act.kind == gila_pkg::KIND_UNIT ||
                         act.kind == gila_pkg::KIND_BOOST) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_STORE;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= scan_issue;
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (scan_end) begin
            state <= (cur_kind == gila_pkg::KIND_UNIT) ? ST_SEARCH : ST_STORE;
          end
        end
        ST_SEARCH: begin
          if (lane_stat.done) begin
            if (lane_stat.lane > largest_lane) begin
              largest_lane <= lane_stat.lane;
            end
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          item_count <= item_count + 1'b1;
          if (cur_kind == gila_pkg::KIND_BOOST) begin
            boost_count <= boost_count + 1'b1;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind   <= act.kind;
      cur_start  <= act.start_frame;
      cur_finish <= act.finish_frame;
      cur_want   <= signed'(gila_pkg::WANT_W'(act.target_id))
                    - signed'(gila_pkg::WANT_W'(cfg.initial_units));
      lane_r     <= gila_pkg::NO_LANE;
      pidx_r     <= gila_pkg::NO_LANE;
    end else if (state == ST_SCAN && boost_hit && cur_kind == gila_pkg::KIND_BOOST) begin
      lane_r <= rd_entry.lane;
      pidx_r <= rd_entry.index;
    end else if (state == ST_SEARCH && lane_stat.done) begin
      lane_r <= gila_pkg::SLANE_W'(lane_stat.lane);
      pidx_r <= gila_pkg::SLANE_W'(item_count - boost_count);
    end
    if (state == ST_MUL) begin
      top_r <= prod[gila_pkg::BOX_W-1:0];
    end
    if (out_load) begin
      res.lane             <= lane_r;
      res.production_index <= pidx_r;
      res.box_top          <= top_r;
      res.box_bottom       <= top_r + gila_pkg::BOX_W'(cfg.box_height);
      res.max_lane         <= largest_lane;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= gila_pkg::COUNT_W'(gila_pkg::MAX_ACTIONS))
    else $error("item count beyond capacity");

  a_boost_bound: assert property (@(posedge clk) disable iff (rst)
    boost_count <= item_count)
    else $error("boost count exceeds item count");

  a_max_lane: assert property (@(posedge clk) disable iff (rst)
    (out_load && !lane_r[gila_pkg::SLANE_W-1]) |->
      largest_lane >= lane_r[gila_pkg::LANE_W-1:0])
    else $error("result lane above largest lane");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == ST_SCAN))
    else $error("ram read pending outside scan");

  a_search_done: assert property (@(posedge clk) disable iff (rst)
    lane_stat.done |-> state == ST_SEARCH)
    else $error("lane search finished outside search state");
`endif

endmodule

// File: tb/tb_greedy_interval_lane_assigner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_interval_lane_assigner_core
// drives action requests through the lane assigner under random idling,
// programs the box and unit registers between phases, and compares every
// result field by field with typed expected values or the bench's lane predictor
// ----------------------------------------------------------------------------
module tb_greedy_interval_lane_assigner_core;
  import gila_pkg::*;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam int QUIET_LIMIT = 10000;
  localparam int HOLD_OFF    = 1500;
  localparam int REPORT_MAX  = 10;
  localparam int NUM_PLAN    = 18;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int LONG_ORDER  = MAX_ACTIONS + 14;

  typedef struct packed {
    logic               restart;
    logic [KIND_W-1:0]   kind;
    logic [FRAME_W-1:0]  start_f;
    logic [FRAME_W-1:0]  finish_f;
    logic [TARGET_W-1:0] target;
  } action_t;

  typedef struct packed {
    logic [SLANE_W-1:0] lane;
    logic [SLANE_W-1:0] pidx;
    logic [BOX_W-1:0]   top;
    logic [BOX_W-1:0]   bottom;
    logic [LANE_W-1:0]  max_lane;
  } placement_t;

  typedef struct packed {
    action_t    a;
    logic       typed;
    placement_t p;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  gila_act_if act_bus();
  gila_res_if res_bus();

  greedy_interval_lane_assigner_core dut (
    .clk     (clk),
    .rst     (rst),
    .act     (act_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // lane predictor state
  logic [FRAME_W-1:0] slot_finish [MAX_ACTIONS];
  int                 slot_lane   [MAX_ACTIONS];
  int                 slot_index  [MAX_ACTIONS];
  bit                 slot_ability[MAX_ACTIONS];
  int                 n_stored, n_boosts, top_lane;
  logic [CFG_W-1:0]   cfg_units, cfg_height, cfg_gap;

  placement_t         pending_places[$];
  plan_row_t          plan_rows[NUM_PLAN];
  cfg_t               phase_cfgs[4];
  logic [FRAME_W-1:0] frame_now;
  int                 n_errors = 0;
  int                 hold_cycles = 0;
  bit                 send_idle = 1'b0;
  bit                 recv_idle = 1'b0;
  int                 quiet_cycles = 0;

  function automatic placement_t place_action(action_t a);
    placement_t p;
    logic [MAX_ACTIONS:0] taken;
    int lane, pidx, want, pos, top;
    lane = -1;
    pidx = -1;
    if (a.restart) begin
      n_stored = 0;
      n_boosts = 0;
      top_lane = 0;
    end
    if (n_stored < MAX_ACTIONS) begin
      pos = n_stored;
      if (a.kind == KIND_UNIT) begin
        taken = '0;
        for (int j = 0; j < pos; j++) begin
          if (!slot_ability[j] && a.start_f < slot_finish[j] && slot_lane[j] >= 0)
            taken[slot_lane[j]] = 1'b1;
        end
        lane = 0;
        while (lane < MAX_ACTIONS && taken[lane]) lane++;
        if (lane > top_lane) top_lane = lane;
        pidx = pos - n_boosts;
      end else if (a.kind == KIND_BOOST) begin
        want = int'(a.target) - int'(cfg_units);
        for (int j = 0; j < pos; j++) begin
          if (slot_index[j] == want) begin
            lane = slot_lane[j];
            pidx = slot_index[j];
          end
        end
        n_boosts++;
      end
      slot_finish[pos]  = a.finish_f;
      slot_lane[pos]    = lane;
      slot_index[pos]   = pidx;
      slot_ability[pos] = (a.kind != KIND_UNIT);
      n_stored = pos + 1;
    end
    top = lane * (int'(cfg_height) + int'(cfg_gap));
    p.lane     = SLANE_W'(lane);
    p.pidx     = SLANE_W'(pidx);
    p.top      = BOX_W'(top);
    p.bottom   = BOX_W'(top + int'(cfg_height));
    p.max_lane = LANE_W'(top_lane);
    return p;
  endfunction

  function automatic action_t action_of(bit rs, logic [KIND_W-1:0] k, int s, int f, int t);
    action_t a;
    a.restart  = rs;
    a.kind     = k;
    a.start_f  = FRAME_W'(s);
    a.finish_f = FRAME_W'(f);
    a.target   = TARGET_W'(t);
    return a;
  endfunction

  function automatic placement_t result_of(int lane, int pidx, int top, int bottom, int mx);
    placement_t p;
    p.lane     = SLANE_W'(lane);
    p.pidx     = SLANE_W'(pidx);
    p.top      = BOX_W'(top);
    p.bottom   = BOX_W'(bottom);
    p.max_lane = LANE_W'(mx);
    return p;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic action_t random_action(bit first);
    action_t a;
    int r, hit;
    r = $urandom_range(0, 99);
    a.restart = first || ($urandom_range(0, 49) == 0);
    if (r < 6) begin
      a.kind     = KIND_W'($urandom);
      a.start_f  = FRAME_W'($urandom);
      a.finish_f = FRAME_W'($urandom);
      a.target   = TARGET_W'($urandom);
      return a;
    end
    if (r < 55) a.kind = KIND_UNIT;
    else if (r < 80) a.kind = KIND_BOOST;
    else if (r < 92) a.kind = KIND_OTHER;
    else a.kind = KIND_SPARE;
    frame_now = frame_now + FRAME_W'($urandom_range(0, 40));
    a.start_f = frame_now;
    r = $urandom_range(0, 99);
    if (r < 10) a.finish_f = a.start_f + FRAME_W'($urandom_range(0, 3));
    else if (r < 85) a.finish_f = a.start_f + FRAME_W'($urandom_range(1, 400));
    else a.finish_f = FRAME_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      hit = $urandom_range(0, (n_stored > n_boosts) ? n_stored - n_boosts : 0);
      a.target = TARGET_W'(hit + int'(cfg_units));
    end else if (r < 70) begin
      a.target = TARGET_W'(int'(cfg_units) - 1);
    end else begin
      a.target = TARGET_W'($urandom);
    end
    return a;
  endfunction

  task automatic note_error(string what, int want_v, int got_v);
    n_errors++;
    if (n_errors <= REPORT_MAX)
      $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
  endtask

  task automatic offer(action_t a, bit typed, placement_t typed_p);
    placement_t p;
    int g;
    act_bus.valid        <= 1'b1;
    act_bus.restart      <= a.restart;
    act_bus.kind         <= a.kind;
    act_bus.start_frame  <= a.start_f;
    act_bus.finish_frame <= a.finish_f;
    act_bus.target_id    <= a.target;
    do @(posedge clk); while (!act_bus.ready);
    p = place_action(a);
    pending_places.insert(pending_places.size(), typed ? typed_p : p);
    g = send_idle ? idle_len() : 0;
    if (g > 0) begin
      act_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    act_bus.valid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
  endtask

  task automatic reg_access(bit wr, logic [1:0] idx, logic [CFG_W-1:0] val,
                            output logic [PDATA_W-1:0] rd);
    logic [PDATA_W-1:0] wd;
    wd = $urandom;
    wd[CFG_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b0, idx, '0, rd);
    if (rd !== PDATA_W'(val)) note_error("register read", int'(val), int'(rd));
  endtask

  task automatic program_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b1, idx, val, rd);
    case (idx)
      REG_INITIAL_UNITS: cfg_units = val;
      REG_BOX_HEIGHT:    cfg_height = val;
      REG_BOX_GAP:       cfg_gap = val;
      default: ;
    endcase
    verify_reg(idx, val);
  endtask

  task automatic run_order(int len);
    frame_now = FRAME_W'($urandom);
    for (int i = 0; i < len; i++) offer(random_action(i == 0), 1'b0, '0);
  endtask

  // every unit overlaps all earlier ones, then the order runs past full
  task automatic run_full_order();
    action_t a;
    for (int i = 0; i < LONG_ORDER; i++) begin
      if (i < MAX_ACTIONS)
        a = action_of(i == 0, KIND_UNIT, $urandom_range(0, 1000),
                      int'(FRAME_MAX) - $urandom_range(0, 1000), $urandom);
      else
        a = random_action(1'b0);
      offer(a, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    placement_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_places.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("result with no request pending, lane %0d", int'(res_bus.lane));
      end else begin
        want = pending_places.pop_front();
        if (res_bus.lane !== want.lane)
          note_error("lane", int'($signed(want.lane)), int'(res_bus.lane));
        if (res_bus.production_index !== want.pidx)
          note_error("production_index", int'($signed(want.pidx)),
                     int'(res_bus.production_index));
        if (res_bus.box_top !== want.top)
          note_error("box_top", int'($signed(want.top)), int'(res_bus.box_top));
        if (res_bus.box_bottom !== want.bottom)
          note_error("box_bottom", int'($signed(want.bottom)), int'(res_bus.box_bottom));
        if (res_bus.max_lane !== want.max_lane)
          note_error("max_lane", int'(want.max_lane), int'(res_bus.max_lane));
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        stall_left = idle_len();
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || psel || (act_bus.valid && act_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t c;
    int budget, len;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    act_bus.valid        <= 1'b0;
    act_bus.restart      <= 1'b0;
    act_bus.kind         <= KIND_UNIT;
    act_bus.start_frame  <= '0;
    act_bus.finish_frame <= '0;
    act_bus.target_id    <= '0;
    n_stored   = 0;
    n_boosts   = 0;
    top_lane   = 0;
    cfg_units  = INITIAL_UNITS_RST;
    cfg_height = BOX_HEIGHT_RST;
    cfg_gap    = BOX_GAP_RST;
    frame_now  = '0;

    plan_rows = '{
      '{action_of(0, KIND_UNIT, 0, 100, 0), 1'b1, result_of(0, 0, 0, 20, 0)},
      '{action_of(0, KIND_UNIT, 50, int'(FRAME_MAX), 1023), 1'b1, result_of(1, 1, 23, 43, 1)},
      '{action_of(0, KIND_UNIT, 100, 200, 0), 1'b1, result_of(0, 2, 0, 20, 1)},
      '{action_of(0, KIND_OTHER, 0, 0, 0), 1'b1, result_of(-1, -1, -23, -3, 1)},
      '{action_of(0, KIND_SPARE, int'(FRAME_MAX), int'(FRAME_MAX), 1023), 1'b1,
        result_of(-1, -1, -23, -3, 1)},
      '{action_of(0, KIND_BOOST, 0, 0, 1), 1'b1, result_of(1, 1, 23, 43, 1)},
      '{action_of(0, KIND_BOOST, 0, 0, 1023), 1'b1, result_of(-1, -1, -23, -3, 1)},
      '{action_of(0, KIND_UNIT, 0, 0, 0), 1'b1, result_of(2, 5, 46, 66, 2)},
      '{action_of(0, KIND_UNIT, int'(FRAME_MAX), int'(FRAME_MAX), 0), 1'b1,
        result_of(0, 6, 0, 20, 2)},
      '{action_of(0, KIND_BOOST, 0, 0, 0), 1'b1, result_of(0, 0, 0, 20, 2)},
      '{action_of(1, KIND_UNIT, 5, 10, 0), 1'b1, result_of(0, 0, 0, 20, 0)},
      '{action_of(0, KIND_UNIT, 9, 1, 0), 1'b1, result_of(1, 1, 23, 43, 1)},
      '{action_of(1, KIND_BOOST, 0, 0, 0), 1'b1, result_of(-1, -1, -23, -3, 0)},
      '{action_of(0, KIND_UNIT, 0, 0, 0), 1'b1, result_of(0, 0, 0, 20, 0)},
      '{action_of(0, KIND_BOOST, 0, 0, 0), 1'b1, result_of(0, 0, 0, 20, 0)},
      '{action_of(0, KIND_UNIT, 'h55555, 'hAAAAA, 'h2AA), 1'b0, '0},
      '{action_of(0, KIND_BOOST, 'hAAAAA, 'h55555, 'h155), 1'b0, '0},
      '{action_of(0, KIND_SPARE, 'hAAAAA, 'h55555, 1023), 1'b0, '0}
    };
    phase_cfgs = '{
      '{8'd128, 8'd255, 8'd255},
      '{8'd0,   8'd1,   8'd0},
      '{8'd255, 8'd0,   8'd255},
      '{8'd5,   8'd20,  8'd3}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    verify_reg(REG_INITIAL_UNITS, INITIAL_UNITS_RST);
    verify_reg(REG_BOX_HEIGHT, BOX_HEIGHT_RST);
    verify_reg(REG_BOX_GAP, BOX_GAP_RST);

    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int i = 0; i < NUM_PLAN; i++)
      offer(plan_rows[i].a, plan_rows[i].typed, plan_rows[i].p);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      if (ph < 4) begin
        c = phase_cfgs[ph];
      end else begin
        c.initial_units = CFG_W'($urandom);
        c.box_height    = CFG_W'($urandom_range(1, 255));
        c.box_gap       = CFG_W'($urandom);
      end
      program_reg(REG_INITIAL_UNITS, c.initial_units);
      program_reg(REG_BOX_HEIGHT, c.box_height);
      program_reg(REG_BOX_GAP, c.box_gap);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      // receiver holds off while requests keep coming
      if (ph == 3) begin
        send_idle   = 1'b0;
        hold_cycles = HOLD_OFF;
      end
      if (ph == 0) begin
        run_full_order();
      end else begin
        budget = PHASE_ITEMS;
        while (budget > 0) begin
          len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30) : $urandom_range(30, 80);
          run_order(len);
          budget -= len;
        end
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gila_pkg.sv
hw/rtl/gila_act_if.sv
hw/rtl/gila_res_if.sv
hw/rtl/gila_ram.sv
hw/rtl/gila_cfg_regs.sv
hw/rtl/gila_free_lane.sv
hw/rtl/greedy_interval_lane_assigner_core.sv
tb/tb_greedy_interval_lane_assigner_core.sv
